FILE: rtl/core/tdjm_pkg.sv
// ----------------------------------------------------------------------------
// tdjm_pkg
// Shared constants, types and command/status structs of the timer delay and
// jitter monitor.
// ----------------------------------------------------------------------------
package tdjm_pkg;

    // Tick counter width and the shared divider's divisor width
    localparam int COUNT_BITS = 32;
    localparam int DIV_W      = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    // Divider: one quotient bit per step over a 64-bit dividend
    localparam int DIV_STEPS  = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Field and register widths
    localparam int TS_W       = 64;
    localparam int FREQ_W     = 32;
    localparam int INTV_W     = 20;
    localparam int OUT_W      = 31;
    localparam int DELAY_W    = 32;
    localparam int SUM_W      = 64;
    localparam int US_W       = 20;
    localparam int PART_W     = 32 + US_W;
    localparam int PROD_W     = TS_W + US_W;

    // Constants
    localparam logic [US_W-1:0]    US_PER_SEC     = US_W'(1000000);
    localparam logic [FREQ_W-1:0]  FREQ_RESET     = FREQ_W'(10000000);
    localparam logic [INTV_W-1:0]  INTERVAL_RESET = INTV_W'(1000);
    localparam logic [OUT_W-1:0]   OUT31_MAX      = '1;
    localparam logic [DELAY_W-1:0] DELAY_MAX      = 32'h7FFF_FFFF;

    // Event request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;

    // Which quotient the shared divider is producing
    typedef enum logic [1:0] {
        SEL_US   = 2'b00,
        SEL_MEAN = 2'b01,
        SEL_JIT  = 2'b10
    } div_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     accept;
        logic     mul_lo;
        logic     mul_hi;
        logic     sum;
        logic     div_start;
        div_sel_t div_sel;
        logic     delay;
        logic     acc;
        logic     out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } dp_stat_t;

endpackage

FILE: rtl/core/tdjm_if.sv
// ----------------------------------------------------------------------------
// tdjm_if
// Valid/ready channels of the monitor: timer events in, statistics out.
// ----------------------------------------------------------------------------
interface tdjm_evt_if;
    import tdjm_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, output req_type, output timestamp, input ready);
    modport sink   (input valid, input req_type, input timestamp, output ready);
endinterface

interface tdjm_stat_if;
    import tdjm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OUT_W-1:0]          avg_delay;
    logic [OUT_W-1:0]          jitter;
    logic signed [DELAY_W-1:0] current_delay;

    modport source (output valid, output avg_delay, output jitter, output current_delay,
                    input ready);
    modport sink   (input valid, input avg_delay, input jitter, input current_delay,
                    output ready);
endinterface

FILE: rtl/core/tdjm_div.sv
// ----------------------------------------------------------------------------
// tdjm_div
// Restoring divider, one quotient bit per cycle. The remainder can be
// preloaded so a wide dividend can be split into an upper and lower part.
// ----------------------------------------------------------------------------
module tdjm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tdjm_pkg::SUM_W-1:0]    dividend,
    input  logic [tdjm_pkg::DIV_W-1:0]    divisor,
    input  logic [tdjm_pkg::DIV_W-1:0]    rem_init,
    output logic                          done,
    output logic [tdjm_pkg::SUM_W-1:0]    quotient
);
    import tdjm_pkg::*;

    logic [SUM_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 ge;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});
    end

    // Control: step counter, busy and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= rem_init;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/tdjm_datapath.sv
// ----------------------------------------------------------------------------
// tdjm_datapath
// Configuration, running statistics, microsecond conversion and the shared
// divider, driven step by step by the controller.
// ----------------------------------------------------------------------------
module tdjm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tdjm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tdjm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [tdjm_pkg::TS_W-1:0]         timestamp,
    input  tdjm_pkg::dp_cmd_t                 cmd,
    output tdjm_pkg::dp_stat_t                stat,
    output logic [tdjm_pkg::OUT_W-1:0]        avg_delay,
    output logic [tdjm_pkg::OUT_W-1:0]        jitter,
    output logic signed [tdjm_pkg::DELAY_W-1:0] current_delay
);
    import tdjm_pkg::*;

    // Configuration and statistics state
    logic [FREQ_W-1:0]         freq_reg;
    logic [INTV_W-1:0]         interval_reg;
    logic [TS_W-1:0]           ref_reg;
    logic signed [DELAY_W-1:0] prev_reg;
    logic [SUM_W-1:0]          dsum_reg;
    logic [SUM_W-1:0]          csum_reg;
    logic [COUNT_BITS-1:0]     count_reg;

    // Per-item work registers
    logic [TS_W-1:0]           diff_reg;
    logic [PART_W-1:0]         lo_reg;
    logic [PART_W-1:0]         hi_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      sat_us_reg;
    logic [SUM_W-1:0]          elapsed_reg;
    logic signed [DELAY_W-1:0] delay_reg;
    logic [OUT_W-1:0]          mean_reg;
    logic [OUT_W-1:0]          jit_reg;
    div_sel_t                  sel_reg;

    // Output register
    logic [OUT_W-1:0]          out_mean_reg;
    logic [OUT_W-1:0]          out_jit_reg;
    logic signed [DELAY_W-1:0] out_delay_reg;

    // Divider connections
    logic [SUM_W-1:0]          div_dividend;
    logic [DIV_W-1:0]          div_divisor;
    logic [DIV_W-1:0]          div_rem_init;
    logic                      div_done;
    logic [SUM_W-1:0]          div_quotient;
    logic [OUT_W-1:0]          ratio;

    // Delay and accumulation terms
    logic [SUM_W-1:0]          delay_limit;
    logic signed [DELAY_W:0]   d33;
    logic signed [DELAY_W:0]   p33;
    logic signed [DELAY_W:0]   chg33;
    logic [DELAY_W:0]          abs_delay;
    logic [DELAY_W:0]          abs_change;
    logic [SUM_W:0]            dsum_add;
    logic [SUM_W:0]            csum_add;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg     <= FREQ_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FREQ:     freq_reg     <= cfg_wdata[FREQ_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_wdata[INTV_W-1:0];
                default:      ;
            endcase
        end
    end

    // Divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            SEL_US:
            begin
                div_dividend = prod_reg[SUM_W-1:0];
                div_divisor  = DIV_W'(freq_reg);
                div_rem_init = DIV_W'(prod_reg[PROD_W-1:SUM_W]);
            end
            SEL_MEAN:
            begin
                div_dividend = dsum_reg;
                div_divisor  = DIV_W'(count_reg);
                div_rem_init = '0;
            end
            SEL_JIT:
            begin
                div_dividend = csum_reg;
                div_divisor  = DIV_W'(count_reg);
                div_rem_init = '0;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
                div_rem_init = '0;
            end
        endcase
    end

    tdjm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rem_init (div_rem_init),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Statistic ratio: zero before any tick, clipped to 31 bits
    always_comb
    begin
        if (count_reg == '0)
            ratio = '0;
        else if (div_quotient[SUM_W-1:OUT_W] != '0)
            ratio = OUT31_MAX;
        else
            ratio = div_quotient[OUT_W-1:0];
    end

    // Delay and accumulation terms
    always_comb
    begin
        delay_limit = SUM_W'(interval_reg) + SUM_W'(DELAY_MAX);
        d33         = (DELAY_W+1)'(delay_reg);
        p33         = (DELAY_W+1)'(prev_reg);
        chg33       = d33 - p33;
        abs_delay   = d33[DELAY_W] ? (DELAY_W+1)'(-d33) : d33;
        abs_change  = chg33[DELAY_W] ? (DELAY_W+1)'(-chg33) : chg33;
        dsum_add    = {1'b0, dsum_reg} + (SUM_W+1)'(abs_delay);
        csum_add    = {1'b0, csum_reg} + (SUM_W+1)'(abs_change);
    end

    // Statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg   <= '0;
            prev_reg  <= '0;
            dsum_reg  <= '0;
            csum_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
                ref_reg <= timestamp;
            if (cmd.acc)
            begin
                dsum_reg <= dsum_add[SUM_W] ? '1 : dsum_add[SUM_W-1:0];
                csum_reg <= csum_add[SUM_W] ? '1 : csum_add[SUM_W-1:0];
                if (count_reg != '1)
                    count_reg <= count_reg + 1'b1;
                prev_reg <= delay_reg;
            end
        end
    end

    // Per-item work registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            diff_reg  <= timestamp - ref_reg;
            delay_reg <= '0;
        end
        if (cmd.mul_lo)
            lo_reg <= PART_W'(diff_reg[31:0]) * PART_W'(US_PER_SEC);
        if (cmd.mul_hi)
            hi_reg <= PART_W'(diff_reg[TS_W-1:32]) * PART_W'(US_PER_SEC);
        if (cmd.sum)
            prod_reg <= {hi_reg, 32'b0} + PROD_W'(lo_reg);
        if (cmd.div_start)
        begin
            sel_reg <= cmd.div_sel;
            // Upper product part not below the frequency: quotient overflows
            sat_us_reg <= (FREQ_W'(prod_reg[PROD_W-1:SUM_W]) >= freq_reg);
        end
        if (div_done)
        begin
            case (sel_reg)
                SEL_US:   elapsed_reg <= sat_us_reg ? '1 : div_quotient;
                SEL_MEAN: mean_reg    <= ratio;
                SEL_JIT:  jit_reg     <= ratio;
                default:  ;
            endcase
        end
        if (cmd.delay)
        begin
            if (elapsed_reg >= delay_limit)
                delay_reg <= DELAY_MAX;
            else
                delay_reg <= DELAY_W'(elapsed_reg - SUM_W'(interval_reg));
        end
        if (cmd.out_load)
        begin
            out_mean_reg  <= mean_reg;
            out_jit_reg   <= jit_reg;
            out_delay_reg <= delay_reg;
        end
    end

    assign stat.div_done  = div_done;
    assign avg_delay      = out_mean_reg;
    assign jitter         = out_jit_reg;
    assign current_delay  = out_delay_reg;

endmodule

FILE: rtl/core/tdjm_ctrl.sv
// ----------------------------------------------------------------------------
// tdjm_ctrl
// Sequencer of the monitor: input handshake, datapath steps, divider waits
// and the output valid flag.
// ----------------------------------------------------------------------------
module tdjm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_req_type,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output tdjm_pkg::dp_cmd_t   cmd,
    input  tdjm_pkg::dp_stat_t  stat
);
    import tdjm_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_MUL_LO    = 13'b0000000000010,
        S_MUL_HI    = 13'b0000000000100,
        S_SUM       = 13'b0000000001000,
        S_LOAD_US   = 13'b0000000010000,
        S_WAIT_US   = 13'b0000000100000,
        S_DELAY     = 13'b0000001000000,
        S_ACC       = 13'b0000010000000,
        S_LOAD_MEAN = 13'b0000100000000,
        S_WAIT_MEAN = 13'b0001000000000,
        S_LOAD_JIT  = 13'b0010000000000,
        S_WAIT_JIT  = 13'b0100000000000,
        S_OUT       = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = SEL_US;
        in_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_req_type == REQ_TICK) ? S_MUL_LO : S_LOAD_MEAN;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_LOAD_US;
            end
            S_LOAD_US:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_US;
                state_next    = S_WAIT_US;
            end
            S_WAIT_US:
            begin
                if (stat.div_done)
                    state_next = S_DELAY;
            end
            S_DELAY:
            begin
                cmd.delay  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_LOAD_MEAN;
            end
            S_LOAD_MEAN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_MEAN;
                state_next    = S_WAIT_MEAN;
            end
            S_WAIT_MEAN:
            begin
                if (stat.div_done)
                    state_next = S_LOAD_JIT;
            end
            S_LOAD_JIT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_JIT;
                state_next    = S_WAIT_JIT;
            end
            S_WAIT_JIT:
            begin
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // An accepted transaction always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("tdjm_ctrl: accepted transaction left controller idle");

    // Divider completions only land in a wait state
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_WAIT_US || state_reg == S_WAIT_MEAN ||
                           state_reg == S_WAIT_JIT))
        else $error("tdjm_ctrl: divider done outside a wait state");

    // A finished result waits while the previous one is still held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("tdjm_ctrl: result loaded over a pending transaction");

    // Input is never taken while a divider run is pending
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !in_ready)
        else $error("tdjm_ctrl: ready raised during division");
`endif

endmodule

FILE: rtl/core/timer_delay_jitter_monitor_core.sv
// ----------------------------------------------------------------------------
// timer_delay_jitter_monitor_core
// Measures timer tick delay against a nominal period and reports mean delay
// and jitter statistics.
// ----------------------------------------------------------------------------
// Usage:
//   events (valid/ready): req_type 0 latches the timestamp as reference;
//   req_type 1 is a tick, measured against the previous reference.
//   stats (valid/ready): one transaction per event with avg_delay, jitter and
//   current_delay (0 for a start event).
//   Configuration: cfg_we/cfg_index/cfg_wdata; index 0 counter frequency,
//   index 1 nominal interval in microseconds. Write only while idle.
// Sequencing:
//   One event at a time. A tick runs the multiply steps, the microsecond
//   conversion, delay and accumulation, then mean and jitter; a start event
//   runs only mean and jitter. All three quotients come from the shared
//   bit-serial divider, and the next event is taken once the result is registered.
// Reset: statistics and reference clear, registers return to 10 MHz and
//   1000 us. Receiver stall: the result register holds; a new event is still
//   accepted and processed, then waits until the register is free.
// ----------------------------------------------------------------------------
module timer_delay_jitter_monitor_core (
    input  logic                             clk,
    input  logic                             rst_n,
    tdjm_evt_if.sink                         events,
    tdjm_stat_if.source                      stats,
    input  logic                             cfg_we,
    input  logic [tdjm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tdjm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tdjm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    tdjm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (events.valid),
        .in_req_type (events.req_type),
        .in_ready    (events.ready),
        .out_valid   (stats.valid),
        .out_ready   (stats.ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Arithmetic and state
    tdjm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .timestamp     (events.timestamp),
        .cmd           (cmd),
        .stat          (stat),
        .avg_delay     (stats.avg_delay),
        .jitter        (stats.jitter),
        .current_delay (stats.current_delay)
    );

endmodule

FILE: verif/tdjm_delay_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tdjm_delay_checker
// Watches the event, statistics and configuration ports of the monitor. It
// keeps its own copy of the reference, delay history, sums and tick count,
// predicts the statistics for every accepted event, and compares each
// accepted statistics transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tdjm_delay_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             evt_valid,
    input  logic                             evt_ready,
    input  logic                             evt_req_type,
    input  logic [tdjm_pkg::TS_W-1:0]        evt_timestamp,
    input  logic                             stat_valid,
    input  logic                             stat_ready,
    input  logic [tdjm_pkg::OUT_W-1:0]       stat_avg_delay,
    input  logic [tdjm_pkg::OUT_W-1:0]       stat_jitter,
    input  logic [tdjm_pkg::DELAY_W-1:0]     stat_current_delay,
    input  logic                             cfg_we,
    input  logic [tdjm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tdjm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               results_pending,
    output int                               mismatch_count
);
    import tdjm_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0]   avg_delay;
        logic [OUT_W-1:0]   jitter;
        logic [DELAY_W-1:0] current_delay;
    } stats_t;

    // Mirrored registers and measurement state
    logic [FREQ_W-1:0]     freq_hz;
    logic [INTV_W-1:0]     period_us;
    logic [TS_W-1:0]       ref_stamp;
    logic [DELAY_W-1:0]    prior_delay;
    logic [SUM_W-1:0]      delay_sum;
    logic [SUM_W-1:0]      change_sum;
    logic [COUNT_BITS-1:0] ticks_seen;

    stats_t expected_stats[$];

    // Counter distance to whole microseconds; all ones when it does not fit or the frequency is zero
    function automatic logic [63:0] elapsed_us(input logic [63:0] span,
                                               input logic [31:0] hz);
        logic [127:0] product;
        logic [127:0] quotient;
        if (hz == '0)
            return '1;
        product  = {64'd0, span} * 128'(US_PER_SEC);
        quotient = product / {96'd0, hz};
        return (quotient[127:64] != '0) ? '1 : quotient[63:0];
    endfunction

    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[SUM_W] ? '1 : total[SUM_W-1:0];
    endfunction

    // Truncated average, zero before any tick, clipped to the 31-bit output range
    function automatic logic [OUT_W-1:0] average31(input logic [SUM_W-1:0] total,
                                                   input logic [COUNT_BITS-1:0] n);
        logic [SUM_W-1:0] q;
        if (n == '0)
            return '0;
        q = total / SUM_W'(n);
        return (q > SUM_W'(OUT31_MAX)) ? OUT31_MAX : q[OUT_W-1:0];
    endfunction

    // Advance the mirrored state by one event and return its statistics
    function automatic stats_t measure_event(input logic is_tick,
                                             input logic [TS_W-1:0] stamp);
        stats_t           res;
        logic [63:0]      el;
        logic signed [63:0] dly;
        logic signed [63:0] chg;
        logic [63:0]      mag_delay;
        logic [63:0]      mag_change;
        dly = '0;
        if (is_tick) begin
            el = elapsed_us(stamp - ref_stamp, freq_hz);
            ref_stamp = stamp;
            if (el >= 64'(period_us) + 64'(DELAY_MAX))
                dly = 64'(DELAY_MAX);
            else
                dly = el - 64'(period_us);
            chg = dly - {{32{prior_delay[31]}}, prior_delay};
            mag_delay  = dly[63] ? -dly : dly;
            mag_change = chg[63] ? -chg : chg;
            delay_sum  = sum_sat(delay_sum, mag_delay);
            change_sum = sum_sat(change_sum, mag_change);
            if (ticks_seen != '1)
                ticks_seen = ticks_seen + 1'b1;
            prior_delay = dly[31:0];
        end
        else begin
            ref_stamp = stamp;
        end
        res.avg_delay     = average31(delay_sum, ticks_seen);
        res.jitter        = average31(change_sum, ticks_seen);
        res.current_delay = dly[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string note);
        $display("%0t: stats mismatch: %s", $time, note);
        mismatch_count++;
    endtask

    // Track configuration, queue predictions, check results
    always @(posedge clk or negedge rst_n) begin : watch
        stats_t want;
        if (!rst_n) begin
            freq_hz     = FREQ_RESET;
            period_us   = INTERVAL_RESET;
            ref_stamp   = '0;
            prior_delay = '0;
            delay_sum   = '0;
            change_sum  = '0;
            ticks_seen  = '0;
            expected_stats.delete();
            results_pending = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_FREQ)
                    freq_hz = cfg_wdata[FREQ_W-1:0];
                else if (cfg_index == CFG_INTERVAL)
                    period_us = cfg_wdata[INTV_W-1:0];
            end

            if (stat_valid && stat_ready) begin
                if (expected_stats.size() == 0) begin
                    report_mismatch("statistics transaction with no event pending");
                end
                else begin
                    want = expected_stats.pop_front();
                    if (stat_avg_delay !== want.avg_delay)
                        report_mismatch($sformatf("avg_delay got %0d want %0d",
                                                  stat_avg_delay, want.avg_delay));
                    if (stat_jitter !== want.jitter)
                        report_mismatch($sformatf("jitter got %0d want %0d",
                                                  stat_jitter, want.jitter));
                    if (stat_current_delay !== want.current_delay)
                        report_mismatch($sformatf("current_delay got %0d want %0d",
                                                  $signed(stat_current_delay),
                                                  $signed(want.current_delay)));
                end
            end

            if (evt_valid && evt_ready)
                expected_stats.push_back(measure_event(evt_req_type == REQ_TICK,
                                                       evt_timestamp));

            results_pending = expected_stats.size();
        end
    end

endmodule

FILE: verif/tb_timer_delay_jitter_monitor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timer_delay_jitter_monitor_core
// Drives timer events and register writes into the monitor and gives the
// verdict. A directed run covers the timestamp and register extremes, counter
// wrap, zero frequency and the saturating cases; random phases then send
// jittered periodic ticks with some restarts and noise under several register
// settings, with bursty events and a stalling statistics receiver.
// ----------------------------------------------------------------------------
module tb_timer_delay_jitter_monitor_core;
    import tdjm_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  HOLD_CYCLES = 3000;
    localparam int  PHASES      = 7;
    localparam int  PHASE_ITEMS = 62;
    localparam int  TAIL_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int results_pending;
    int mismatch_count;
    int cycle_count;
    int burst_left;
    bit hold_off_req;

    tdjm_evt_if  events_if ();
    tdjm_stat_if stats_if ();

    timer_delay_jitter_monitor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events_if),
        .stats     (stats_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tdjm_delay_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .evt_valid          (events_if.valid),
        .evt_ready          (events_if.ready),
        .evt_req_type       (events_if.req_type),
        .evt_timestamp      (events_if.timestamp),
        .stat_valid         (stats_if.valid),
        .stat_ready         (stats_if.ready),
        .stat_avg_delay     (stats_if.avg_delay),
        .stat_jitter        (stats_if.jitter),
        .stat_current_delay (stats_if.current_delay),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .results_pending    (results_pending),
        .mismatch_count     (mismatch_count)
    );

    // Clock
    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Run limit
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[timer_delay_jitter_monitor_core] ERROR");
            $finish;
        end
    end

    // Register write, called at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one event; bursts of random length with random gaps between them
    task automatic offer_event(input logic kind, input logic [TS_W-1:0] stamp);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 20);
                default: gap = $urandom_range(20, 260);
            endcase
            if (gap != 0) begin
                events_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        events_if.valid     <= 1'b1;
        events_if.req_type  <= kind;
        events_if.timestamp <= stamp;
        do @(posedge clk); while (!events_if.ready);
        @(negedge clk);
    endtask

    // Stop sending and wait for every outstanding statistics transaction
    task automatic wait_idle();
        events_if.valid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        burst_left = 0;
    endtask

    // Next tick distance: nominal period with a random error around it
    function automatic logic [63:0] jittered_period(input logic [63:0] nominal);
        logic [63:0] spread;
        spread = (nominal >> 3) + ((nominal < 64) ? 64'd1 : 64'd20);
        if (spread > 64'h3FFF_FFFF)
            spread = 64'h3FFF_FFFF;
        return nominal - spread + 64'($urandom_range(0, 32'(2 * spread)));
    endfunction

    // Statistics receiver: stall pattern of its own plus one long hold-off
    initial begin : receiver
        int mode;
        int span;
        int step;
        stats_if.ready = 1'b0;
        mode = 0;
        span = 0;
        step = 0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                stats_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 400);
            end
            span--;
            step++;
            case (mode)
                0:       stats_if.ready <= 1'b1;
                1:       stats_if.ready <= ($urandom_range(0, 1) == 1);
                2:       stats_if.ready <= ((step % 5) != 0);
                default: stats_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [TS_W-1:0]   clock_ts;
        logic [63:0]       nominal;
        logic [FREQ_W-1:0] hz;
        logic [INTV_W-1:0] us;
        int                pick;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_FREQ;
        cfg_wdata           = '0;
        events_if.valid     = 1'b0;
        events_if.req_type  = REQ_START;
        events_if.timestamp = '0;
        burst_left          = 0;
        hold_off_req        = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Delay swings between both extremes on the first ticks: jitter clips
        write_reg(CFG_INTERVAL, 32'h000F_FFFF);
        offer_event(REQ_TICK, 64'h0000_1000_0000_0000);
        offer_event(REQ_TICK, 64'h0000_1000_0000_0001);
        wait_idle();
        write_reg(CFG_INTERVAL, CFG_DATA_W'(INTERVAL_RESET));

        // Exact period, truncation, early and late ticks at the reset rate
        offer_event(REQ_START, 64'd0);
        offer_event(REQ_TICK, 64'd10000);
        offer_event(REQ_TICK, 64'd20007);
        offer_event(REQ_TICK, 64'd29007);
        offer_event(REQ_TICK, 64'd40006);
        // Counter wrap between start and tick
        offer_event(REQ_START, 64'hFFFF_FFFF_FFFF_FF00);
        offer_event(REQ_TICK, 64'h0000_0000_0000_2610);
        // Far-late tick: delay clips high
        offer_event(REQ_TICK, 64'h0000_1000_0000_2610);
        // Zero distance, then the whole counter range
        offer_event(REQ_START, '1);
        offer_event(REQ_TICK, '1);
        offer_event(REQ_START, 64'd0);
        offer_event(REQ_TICK, '1);
        wait_idle();

        // Slowest counter, zero interval; conversion overflows 64 bits
        write_reg(CFG_FREQ, 32'd1);
        write_reg(CFG_INTERVAL, 32'd0);
        offer_event(REQ_START, 64'd0);
        offer_event(REQ_TICK, 64'd1);
        offer_event(REQ_TICK, 64'h0000_2000_0000_0001);
        wait_idle();

        // Zero frequency: every tick clips high
        write_reg(CFG_FREQ, 32'd0);
        offer_event(REQ_TICK, {$urandom(), $urandom()});
        offer_event(REQ_START, {$urandom(), $urandom()});
        wait_idle();

        // Fastest counter, a one-second nominal interval
        write_reg(CFG_FREQ, 32'hFFFF_FFFF);
        write_reg(CFG_INTERVAL, 32'd1_000_000);
        offer_event(REQ_START, 64'd0);
        offer_event(REQ_TICK, 64'd1);
        offer_event(REQ_TICK, '1);
        wait_idle();

        // Random phases, one register setting each
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin hz = 32'd10_000_000;  us = 20'd1000;      end
                1: begin hz = 32'd1;           us = 20'd1_000_000; end
                2: begin hz = 32'hFFFF_FFFF;   us = 20'd1;         end
                3: begin hz = 32'd24_000_000;  us = 20'd125;       end
                4: begin
                    hz = $urandom_range(1000, 100_000_000);
                    us = INTV_W'($urandom_range(0, 1_000_000));
                end
                5: begin
                    hz = $urandom();
                    us = INTV_W'($urandom_range(0, 20'hFFFFF));
                end
                default: begin
                    hz = $urandom_range(1, 1000);
                    us = INTV_W'($urandom_range(1, 1_000_000));
                end
            endcase
            write_reg(CFG_FREQ, hz);
            write_reg(CFG_INTERVAL, CFG_DATA_W'(us));
            nominal = 64'(hz) * 64'(us) / 64'(US_PER_SEC);

            // Start close to the wrap point now and then
            if ($urandom_range(0, 2) == 0)
                clock_ts = 64'd0 - nominal * 64'($urandom_range(1, 4));
            else
                clock_ts = {$urandom(), $urandom()};
            offer_event(REQ_START, clock_ts);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Long receiver hold-off while events keep coming
                if (p == 0 && i == 20)
                    hold_off_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    // restart, sometimes from a random counter value
                    if (pick < 3)
                        clock_ts = {$urandom(), $urandom()};
                    offer_event(REQ_START, clock_ts);
                end
                else if (pick < 14) begin
                    // noise: unrelated timestamp of either kind
                    offer_event(($urandom_range(0, 1) == 0) ? REQ_START : REQ_TICK,
                                {$urandom(), $urandom()});
                end
                else if (pick < 18) begin
                    // very late tick
                    clock_ts = clock_ts + ({$urandom(), $urandom()} >> $urandom_range(8, 63));
                    offer_event(REQ_TICK, clock_ts);
                end
                else begin
                    clock_ts = clock_ts + jittered_period(nominal);
                    offer_event(REQ_TICK, clock_ts);
                end
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("[timer_delay_jitter_monitor_core] OK");
        else
            $display("[timer_delay_jitter_monitor_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tdjm_pkg.sv
rtl/core/tdjm_if.sv
rtl/core/tdjm_div.sv
rtl/core/tdjm_datapath.sv
rtl/core/tdjm_ctrl.sv
rtl/core/timer_delay_jitter_monitor_core.sv
verif/tdjm_delay_checker.sv
verif/tb_timer_delay_jitter_monitor_core.sv
